@@ hw/rtl/tprs_pkg.sv @@
// shared widths, defaults and command codes for the path-to-root sum block
package tprs_pkg;
  localparam int FIELD_W       = 11;
  localparam int VALUE_W       = 32;
  localparam int SUM_W         = 42;
  localparam int CMD_W         = 2;
  localparam int MAX_NODES_DEF = 1024;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_SET   = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;
endpackage

@@ hw/rtl/tree_path_to_root_sum.sv @@
// path-to-root sums over a heavy-light decomposed tree, one shared sum-tree port
//
// Input channel (in_valid/in_ready) carries cmd, node, position, head_position,
// head_parent and value. A load writes the three node tables in the accept
// cycle. A set reads the node position, walks down the sum tree one level a
// cycle, writes the leaf, then rebuilds each parent by reading the left child,
// reading the right child and writing their sum (S_UPL, S_UPR, S_UPW).
// A query walks chain by chain: a table lookup per chain (S_QCHK, S_QTAB), then
// a range sum that visits the segment-tree nodes one per cycle, with an added
// node also passing through S_RACC, and keeps pending nodes on a small stack.
// In_ready is low while an item is worked on.
// Results leave on out_valid/out_ready with path_sum held in a register; a new
// item is accepted while a result waits, and a finishing query holds until the
// output register is free.
// After reset the 4 * MAX_NODES sum-tree entries are cleared one entry a cycle,
// with in_ready low; node_count writes are taken at any time.
module tree_path_to_root_sum #(
  parameter int MAX_NODES = tprs_pkg::MAX_NODES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             node_count_we,
  input  logic [tprs_pkg::FIELD_W-1:0]     node_count_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [tprs_pkg::CMD_W-1:0]       cmd,
  input  logic [tprs_pkg::FIELD_W-1:0]     node,
  input  logic [tprs_pkg::FIELD_W-1:0]     position,
  input  logic [tprs_pkg::FIELD_W-1:0]     head_position,
  input  logic [tprs_pkg::FIELD_W-1:0]     head_parent,
  input  logic [tprs_pkg::VALUE_W-1:0]     value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [tprs_pkg::SUM_W-1:0]       path_sum
);
  import tprs_pkg::*;

  localparam int TREE   = 4 * MAX_NODES;
  localparam int TAW    = $clog2(TREE);
  localparam int IW     = TAW + 1;
  localparam int TIW    = $clog2(MAX_NODES);
  localparam int CW     = $clog2(MAX_NODES + 1);
  localparam int LW     = (CW > FIELD_W) ? CW : FIELD_W;
  localparam int SD     = $clog2(MAX_NODES) + 3;
  localparam int SPW    = $clog2(SD + 1);
  localparam int STW    = $clog2(MAX_NODES + 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SETPOS, S_DESC, S_UPL, S_UPR, S_UPW,
    S_QCHK, S_QTAB, S_RNODE, S_RACC, S_DONE
  } state_t;

  typedef struct packed {
    logic [IW-1:0] idx;
    logic [LW-1:0] lo;
    logic [LW-1:0] hi;
  } span_t;

  state_t state;

  logic [LW-1:0]      ncount;
  logic [TAW-1:0]     clr_addr;
  logic [IW-1:0]      idx;
  logic [LW-1:0]      lo, hi, ra, rb;
  logic [VALUE_W-1:0] set_value;
  logic [SUM_W-1:0]   left_sum, sum;
  logic [FIELD_W-1:0] u;
  logic [STW-1:0]     steps;
  logic [SPW-1:0]     sp;
  span_t              stk [SD];

  // node tables and sum tree
  logic [FIELD_W-1:0] tab_pos   [MAX_NODES];
  logic [FIELD_W-1:0] tab_hpos  [MAX_NODES];
  logic [FIELD_W-1:0] tab_hpar  [MAX_NODES];
  logic [FIELD_W-1:0] pos_q, hpos_q, hpar_q;
  logic [SUM_W-1:0]   tree [TREE];
  logic [SUM_W-1:0]   t_rdata;

  logic               accept, node_ok, tab_we, tab_re, walk_ok;
  logic [TIW-1:0]     tab_waddr, tab_raddr;
  logic               t_we, t_re;
  logic [TAW-1:0]     t_waddr, t_raddr;
  logic [SUM_W-1:0]   t_wdata;
  logic [LW:0]        mid_w;
  logic [LW-1:0]      mid, qa, qb;
  logic               r_skip, r_full;
  logic [LW-1:0]      nc_clamp;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign node_ok  = (node != '0) && (32'(node) <= MAX_NODES);
  assign walk_ok  = (u != '0) && (32'(u) <= MAX_NODES) && (32'(steps) < MAX_NODES);

  assign mid_w = ({1'b0, lo} + {1'b0, hi}) >> 1;
  assign mid   = mid_w[LW-1:0];

  // chain range clamped to 1..node_count
  assign qa = (hpos_q == '0) ? LW'(1) : LW'(hpos_q);
  assign qb = (LW'(pos_q) > ncount) ? ncount : LW'(pos_q);

  assign r_skip = (32'(idx) >= TREE) || (lo > rb) || (hi < ra);
  assign r_full = (ra <= lo) && (hi <= rb);

  always_comb begin
    if (node_count_wdata == '0) begin
      nc_clamp = LW'(1);
    end else if (32'(node_count_wdata) > MAX_NODES) begin
      nc_clamp = LW'(MAX_NODES);
    end else begin
      nc_clamp = LW'(node_count_wdata);
    end
  end

  always_comb begin
    tab_we    = accept && (cmd == CMD_LOAD) && node_ok;
    tab_waddr = TIW'(node - 1'b1);
    tab_re    = 1'b0;
    tab_raddr = TIW'(node - 1'b1);
    if (accept && (cmd == CMD_SET) && node_ok) begin
      tab_re = 1'b1;
    end else if (state == S_QCHK && walk_ok) begin
      tab_re    = 1'b1;
      tab_raddr = TIW'(u - 1'b1);
    end
  end

  always_comb begin
    t_we    = 1'b0;
    t_waddr = idx[TAW-1:0];
    t_wdata = left_sum + t_rdata;
    t_re    = 1'b0;
    t_raddr = idx[TAW-1:0];
    unique case (state)
      S_CLEAR: begin
        t_we    = 1'b1;
        t_waddr = clr_addr;
        t_wdata = '0;
      end
      S_DESC: begin
        t_we    = (lo >= hi) && (32'(idx) < TREE);
        t_wdata = SUM_W'(set_value);
      end
      S_UPL: begin
        t_re    = 1'b1;
        t_raddr = {idx[TAW-1:1], 1'b0};
      end
      S_UPR: begin
        t_re    = 1'b1;
        t_raddr = {idx[TAW-1:1], 1'b1};
      end
      S_UPW: begin
        t_we    = 1'b1;
        t_waddr = TAW'(idx >> 1);
      end
      S_RNODE: begin
        t_re = !r_skip && r_full;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (tab_we) begin
      tab_pos[tab_waddr]  <= position;
      tab_hpos[tab_waddr] <= head_position;
      tab_hpar[tab_waddr] <= head_parent;
    end
    if (tab_re) begin
      pos_q  <= tab_pos[tab_raddr];
      hpos_q <= tab_hpos[tab_raddr];
      hpar_q <= tab_hpar[tab_raddr];
    end
    if (t_we) begin
      tree[t_waddr] <= t_wdata;
    end
    if (t_re) begin
      t_rdata <= tree[t_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      ncount    <= LW'(1);
      out_valid <= 1'b0;
      sp        <= '0;
    end else begin
      if (node_count_we) begin
        ncount <= nc_clamp;
      end
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (32'(clr_addr) == TREE - 1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            set_value <= value;
            sum       <= '0;
            u         <= node;
            steps     <= '0;
            sp        <= '0;
            if (cmd == CMD_SET && node_ok) begin
              state <= S_SETPOS;
            end else if (cmd == CMD_QUERY) begin
              state <= S_QCHK;
            end
          end
        end
        S_SETPOS: begin
          idx <= IW'(1);
          lo  <= LW'(1);
          hi  <= ncount;
          if (pos_q != '0 && LW'(pos_q) <= ncount) begin
            state <= S_DESC;
          end else begin
            state <= S_IDLE;
          end
        end
        S_DESC: begin
          if (lo < hi) begin
            if (LW'(pos_q) <= mid) begin
              hi  <= mid;
              idx <= {idx[IW-2:0], 1'b0};
            end else begin
              lo  <= mid + 1'b1;
              idx <= {idx[IW-2:0], 1'b1};
            end
          end else if (32'(idx) < TREE && idx > IW'(1)) begin
            state <= S_UPL;
          end else begin
            state <= S_IDLE;
          end
        end
        S_UPL: begin
          state <= S_UPR;
        end
        S_UPR: begin
          left_sum <= t_rdata;
          state    <= S_UPW;
        end
        S_UPW: begin
          idx <= idx >> 1;
          if ((idx >> 1) > IW'(1)) begin
            state <= S_UPL;
          end else begin
            state <= S_IDLE;
          end
        end
        S_QCHK: begin
          if (walk_ok) begin
            state <= S_QTAB;
          end else begin
            state <= S_DONE;
          end
        end
        S_QTAB: begin
          u     <= hpar_q;
          steps <= steps + 1'b1;
          ra    <= qa;
          rb    <= qb;
          idx   <= IW'(1);
          lo    <= LW'(1);
          hi    <= ncount;
          sp    <= '0;
          state <= (qa <= qb) ? S_RNODE : S_QCHK;
        end
        S_RNODE: begin
          if (r_skip) begin
            // node outside the range: take the next pending node
            if (sp == '0) begin
              state <= S_QCHK;
            end else begin
              sp  <= sp - 1'b1;
              idx <= stk[sp - 1'b1].idx;
              lo  <= stk[sp - 1'b1].lo;
              hi  <= stk[sp - 1'b1].hi;
            end
          end else if (r_full) begin
            state <= S_RACC;
          end else begin
            stk[sp] <= '{idx: {idx[IW-2:0], 1'b1}, lo: mid + 1'b1, hi: hi};
            sp      <= sp + 1'b1;
            idx     <= {idx[IW-2:0], 1'b0};
            hi      <= mid;
          end
        end
        S_RACC: begin
          sum <= sum + t_rdata;
          if (sp == '0) begin
            state <= S_QCHK;
          end else begin
            sp    <= sp - 1'b1;
            idx   <= stk[sp - 1'b1].idx;
            lo    <= stk[sp - 1'b1].lo;
            hi    <= stk[sp - 1'b1].hi;
            state <= S_RNODE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            path_sum  <= sum;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule

@@ tb/sv/tb_top.sv @@
// testbench for tree_path_to_root_sum: random tree loads, sets and path queries
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tprs_pkg::*;

  localparam int NODES     = 1024;
  localparam int TREE_LEN  = 4 * NODES;
  localparam int LIMIT     = 20000000;
  localparam int SHOW_MAX  = 10;

  typedef struct {
    cmd_t                cmd;
    logic [FIELD_W-1:0]  node;
    logic [FIELD_W-1:0]  pos;
    logic [FIELD_W-1:0]  hpos;
    logic [FIELD_W-1:0]  hpar;
    logic [VALUE_W-1:0]  val;
  } tree_op_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic node_count_we = 1'b0;
  logic [FIELD_W-1:0] node_count_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [CMD_W-1:0] cmd = CMD_NONE;
  logic [FIELD_W-1:0] node = '0;
  logic [FIELD_W-1:0] position = '0;
  logic [FIELD_W-1:0] head_position = '0;
  logic [FIELD_W-1:0] head_parent = '0;
  logic [VALUE_W-1:0] value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [SUM_W-1:0] path_sum;

  tree_path_to_root_sum u_dut (
    .clk(clk), .rst(rst),
    .node_count_we(node_count_we), .node_count_wdata(node_count_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .node(node), .position(position), .head_position(head_position),
    .head_parent(head_parent), .value(value),
    .out_valid(out_valid), .out_ready(out_ready), .path_sum(path_sum)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // mirror of the block state
  logic [SUM_W-1:0]   seg_sums [TREE_LEN];
  logic [FIELD_W-1:0] tbl_pos  [NODES];
  logic [FIELD_W-1:0] tbl_hpos [NODES];
  logic [FIELD_W-1:0] tbl_hpar [NODES];
  int                 span_n = 1;

  tree_op_t           pending_ops[$];
  logic [SUM_W-1:0]   expected_sums[$];
  int                 errors = 0;
  int                 cycles = 0;

  function automatic logic [SUM_W-1:0] seg_total(int idx, int lo, int hi, int a, int b);
    int mid;
    if (idx >= TREE_LEN || lo > b || hi < a) return '0;
    if (a <= lo && hi <= b) return seg_sums[idx];
    mid = (lo + hi) >> 1;
    return seg_total(2 * idx, lo, mid, a, b) + seg_total(2 * idx + 1, mid + 1, hi, a, b);
  endfunction

  function automatic void seg_write(int p, logic [VALUE_W-1:0] v);
    int idx, lo, hi, mid;
    idx = 1; lo = 1; hi = span_n;
    while (lo < hi) begin
      mid = (lo + hi) >> 1;
      if (p <= mid) begin
        hi = mid; idx = 2 * idx;
      end else begin
        lo = mid + 1; idx = 2 * idx + 1;
      end
    end
    if (idx >= TREE_LEN) return;
    seg_sums[idx] = SUM_W'(v);
    while (idx > 1) begin
      idx = idx >> 1;
      seg_sums[idx] = seg_sums[2 * idx] + seg_sums[2 * idx + 1];
    end
  endfunction

  // applies one accepted item, queues the path sum for a query
  function automatic void tree_apply(tree_op_t op);
    int u, steps, a, b, n;
    logic [SUM_W-1:0] total;
    n = op.node;
    case (op.cmd)
      CMD_LOAD: begin
        if (n >= 1 && n <= NODES) begin
          tbl_pos[n-1] = op.pos; tbl_hpos[n-1] = op.hpos; tbl_hpar[n-1] = op.hpar;
        end
      end
      CMD_SET: begin
        if (n >= 1 && n <= NODES && tbl_pos[n-1] >= 1 && tbl_pos[n-1] <= span_n)
          seg_write(tbl_pos[n-1], op.val);
      end
      CMD_QUERY: begin
        total = '0; u = n; steps = 0;
        while (u != 0 && u <= NODES && steps < NODES) begin
          a = tbl_hpos[u-1];
          b = tbl_pos[u-1];
          if (a < 1) a = 1;
          if (b > span_n) b = span_n;
          if (a <= b) total = total + seg_total(1, 1, span_n, a, b);
          u = tbl_hpar[u-1];
          steps++;
        end
        expected_sums = {expected_sums, total};
      end
      default: ;
    endcase
  endfunction

  initial begin
    for (int i = 0; i < TREE_LEN; i++) seg_sums[i] = '0;
    for (int i = 0; i < NODES; i++) begin
      tbl_pos[i] = '0; tbl_hpos[i] = '0; tbl_hpar[i] = '0;
    end
  end

  // sender: bursts of items with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    tree_op_t op;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        op = pending_ops.pop_front();
        cmd <= op.cmd; node <= op.node; position <= op.pos;
        head_position <= op.hpos; head_parent <= op.hpar; value <= op.val;
        in_valid <= 1'b1;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    tree_op_t op;
    if (!rst && in_valid && in_ready) begin
      op.cmd = cmd_t'(cmd); op.node = node; op.pos = position;
      op.hpos = head_position; op.hpar = head_parent; op.val = value;
      tree_apply(op);
    end
  end

  // receiver: stall pattern drawn at random from three ready modes, plus a long hold now and then
  int stall_left = 0;
  int ready_mode = 0;
  always @(posedge clk) begin
    logic [SUM_W-1:0] want;
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_sums.size() == 0) begin
          errors++;
          if (errors <= SHOW_MAX) $display("unexpected path_sum %0d", path_sum);
        end else begin
          want = expected_sums.pop_front();
          if (path_sum !== want) begin
            errors++;
            if (errors <= SHOW_MAX)
              $display("path_sum mismatch: expected %0d got %0d", want, path_sum);
          end
        end
      end
      if (cycles % 64 == 0) ready_mode <= $urandom_range(0, 2);
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 1'b0;
      end else if (cycles % 20000 == 9000) begin
        stall_left <= 700;
        out_ready <= 1'b0;
      end else begin
        case (ready_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= $urandom_range(0, 1);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  function automatic tree_op_t mk_op(cmd_t c, int n, int p = 0, int hp = 0, int par = 0,
                                     logic [VALUE_W-1:0] v = '0);
    tree_op_t op;
    op.cmd = c; op.node = FIELD_W'(n); op.pos = FIELD_W'(p); op.hpos = FIELD_W'(hp);
    op.hpar = FIELD_W'(par); op.val = v;
    return op;
  endfunction

  function automatic void add_op(tree_op_t op);
    pending_ops = {pending_ops, op};
  endfunction

  // let the queue drain and the block go quiet before touching the register
  task automatic wait_quiet();
    while (pending_ops.size() != 0 || in_valid || expected_sums.size() != 0 || !in_ready)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_node_count(int v);
    @(posedge clk);
    node_count_we <= 1'b1;
    node_count_wdata <= FIELD_W'(v);
    @(posedge clk);
    node_count_we <= 1'b0;
    span_n = (v < 1) ? 1 : (v > NODES) ? NODES : v;
  endtask

  int phase_ids[$];
  int shuffled[NODES];
  int dir_queries[8] = '{1024, 5, 6, 7, 8, 9, 0, 2047};

  // well-formed decomposition: contiguous chains, each head hangs off an earlier chain
  task automatic load_tree(int n, int base);
    int k, len, hp, par, j, t;
    for (int i = 0; i < NODES; i++) shuffled[i] = i + 1;
    for (int i = NODES - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = shuffled[i]; shuffled[i] = shuffled[j]; shuffled[j] = t;
    end
    phase_ids.delete();
    k = 0;
    while (k < n) begin
      len = $urandom_range(1, 8);
      hp = base + 1 + k;
      par = (k == 0) ? 0 : shuffled[$urandom_range(0, k - 1)];
      for (int i = 0; i < len && k < n; i++) begin
        add_op(mk_op(CMD_LOAD, shuffled[k], base + 1 + k, hp, par));
        phase_ids = {phase_ids, shuffled[k]};
        k++;
      end
    end
    foreach (phase_ids[i])
      add_op(mk_op(CMD_SET, phase_ids[i], 0, 0, 0, $urandom()));
  endtask

  task automatic random_ops(int count);
    int r, id;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      id = phase_ids[$urandom_range(0, phase_ids.size() - 1)];
      if (r < 45) begin
        add_op(mk_op(CMD_QUERY, id));
      end else if (r < 80) begin
        add_op(mk_op(CMD_SET, id, 0, 0, 0,
          ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF : $urandom()));
      end else if (r < 85) begin
        // broken table entry that still ends the walk
        add_op(mk_op(CMD_LOAD, id, $urandom_range(0, 2047),
          $urandom_range(0, 2047), $urandom_range(0, 1) ? 0 : $urandom_range(1025, 2047)));
      end else if (r < 90) begin
        add_op(mk_op(cmd_t'($urandom_range(0, 2)), $urandom_range(1025, 2047),
          $urandom_range(0, 2047), $urandom_range(0, 2047), $urandom_range(0, 2047),
          $urandom()));
      end else if (r < 94) begin
        add_op(mk_op(CMD_NONE, $urandom_range(0, 2047), $urandom_range(0, 2047),
          $urandom_range(0, 2047), $urandom_range(0, 2047), $urandom()));
      end else if (r < 96) begin
        add_op(mk_op(CMD_QUERY, 0));
      end else begin
        add_op(mk_op(CMD_QUERY, id));
      end
    end
  endtask

  int nc_w, n_tree, base_pos;
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: chains, out-of-range nodes and positions, inverted range, a loop
    write_node_count(6);
    add_op(mk_op(CMD_LOAD, 1, 1, 1, 0));
    add_op(mk_op(CMD_LOAD, 2, 2, 1, 0));
    add_op(mk_op(CMD_LOAD, 3, 3, 3, 2));
    add_op(mk_op(CMD_LOAD, 1024, 4, 3, 2));
    add_op(mk_op(CMD_LOAD, 5, 5, 5, 1));
    add_op(mk_op(CMD_LOAD, 6, 6, 6, 2047));
    add_op(mk_op(CMD_LOAD, 7, 2047, 2047, 0));
    add_op(mk_op(CMD_LOAD, 8, 2, 5, 0));
    add_op(mk_op(CMD_LOAD, 9, 1, 1, 10));
    add_op(mk_op(CMD_LOAD, 10, 2, 2, 9));
    add_op(mk_op(CMD_LOAD, 0, 5, 5, 5));
    add_op(mk_op(CMD_LOAD, 2047, 1, 1, 1));
    add_op(mk_op(CMD_SET, 1, 0, 0, 0, 32'hFFFF_FFFF));
    add_op(mk_op(CMD_SET, 2, 0, 0, 0, 32'hFFFF_FFFF));
    add_op(mk_op(CMD_SET, 3, 0, 0, 0, 32'h0));
    add_op(mk_op(CMD_SET, 1024, 0, 0, 0, 32'hFFFF_FFFF));
    add_op(mk_op(CMD_SET, 5, 0, 0, 0, 32'h1234_5678));
    add_op(mk_op(CMD_SET, 7, 0, 0, 0, 32'hAAAA_5555));
    add_op(mk_op(CMD_SET, 2047, 0, 0, 0, 32'h5555_AAAA));
    add_op(mk_op(CMD_SET, 0, 0, 0, 0, 32'h1));
    add_op(mk_op(CMD_NONE, 1, 1, 1, 1, 32'h1));
    foreach (dir_queries[i])
      add_op(mk_op(CMD_QUERY, dir_queries[i]));
    wait_quiet();

    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: nc_w = 0;
        1: nc_w = 1024;
        2: nc_w = 2047;
        3: nc_w = 1;
        default: nc_w = $urandom_range(2, 1024);
      endcase
      write_node_count(nc_w);
      n_tree = (span_n < 50) ? span_n : $urandom_range(10, 50);
      base_pos = (ph % 2 == 1) ? span_n - n_tree : $urandom_range(0, span_n - n_tree);
      load_tree(n_tree, base_pos);
      random_ops((ph == 3) ? 60 : 140);
      wait_quiet();
    end

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
